// ----- design/fpmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpmq_pkg;

  // Field widths.
  localparam int FREQ_W    = 36;
  localparam int THR_W     = 24;
  localparam int COUNT_W   = 24;
  localparam int PERIOD_W  = 32;
  localparam int BYTE_W    = 8;
  localparam int HALF_W    = 16;

  // Default number of fraction bits of a frequency.
  localparam int FRAC_BITS_DEF = 8;

  // Reset value of the count switch threshold.
  localparam logic [THR_W-1:0] THR_RESET = 24'd1000;

  // Numerator of the period path before the fraction shift, below 2^20.
  localparam logic [63:0] DIV_NUM   = 64'd1000000;
  localparam int          DIV_NUM_W = 20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clear_valid;
    logic load_count;
    logic load_zero;
    logic div_start;
    logic div_step;
    logic qualify;
    logic load_out;
  } fpmq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic freq_ready;
    logic period_ready;
    logic use_count;
    logic period_zero;
    logic div_last;
    logic out_free;
  } fpmq_sts_t;

endpackage

`default_nettype wire

// ----- design/fpmq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpmq_ctrl
  import fpmq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire fpmq_sts_t sts,
  output fpmq_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_QUAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Input transfers are taken only while no item is in flight.
  assign in_tready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts.mode) begin
          cmd.clear_valid = 1'b1;
          state_nxt       = ST_DONE;
        end else if (!sts.freq_ready) begin
          state_nxt = ST_DONE;
        end else if (sts.use_count) begin
          cmd.load_count = 1'b1;
          state_nxt      = ST_QUAL;
        end else if (sts.period_ready) begin
          if (sts.period_zero) begin
            cmd.load_zero = 1'b1;
            state_nxt     = ST_QUAL;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_QUAL;
        end
      end
      ST_QUAL: begin
        cmd.qualify = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/fpmq_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpmq_dp
  import fpmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [THR_W-1:0]    cfg_wr_data,
  input  wire logic [2:0]          in_tuser,
  input  wire logic [47:0]         in_tdata,
  input  wire logic                out_tready,
  output logic                     out_tvalid,
  output logic [39:0]              out_tdata,
  output logic                     out_tuser,
  input  wire fpmq_cmd_t           cmd,
  output fpmq_sts_t                sts
);

  // Dividend of the period path and the length of the serial division.
  localparam int                DVD_W    = DIV_NUM_W + FRAC_BITS;
  localparam int                CNT_W    = $clog2(DVD_W);
  localparam logic [DVD_W-1:0]  DIVIDEND = DVD_W'(DIV_NUM << FRAC_BITS);
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
  localparam logic [FREQ_W-1:0] SAT_LIM  = FREQ_MAX >> FRAC_BITS;

  logic [THR_W-1:0]    thr_r;
  logic                mode_r;
  logic                fready_r;
  logic                pready_r;
  logic [COUNT_W-1:0]  count_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [DVD_W-1:0]    dvd_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [FREQ_W-1:0]   meas_r;
  logic [FREQ_W-1:0]   meas_nxt;
  logic [FREQ_W-1:0]   last_r;
  logic [FREQ_W-1:0]   acc_freq_r;
  logic                acc_valid_r;
  logic                out_valid_r;
  logic [FREQ_W-1:0]   out_freq_r;
  logic                out_flag_r;

  logic [COUNT_W+3:0]  count_x10;
  logic [FREQ_W-1:0]   count_freq;
  logic [PERIOD_W:0]   rem_shift;
  logic [PERIOD_W:0]   rem_diff;
  logic                q_bit;
  logic [FREQ_W+3:0]   f_x10;
  logic [FREQ_W+3:0]   prev_x9;
  logic [FREQ_W+3:0]   prev_x11;
  logic                reject;

  // Count path: count times ten, shifted into fixed point, saturated.
  assign count_x10 = ({4'b0, count_r} << 3) + ({4'b0, count_r} << 1);
  always_comb begin
    if (FREQ_W'(count_x10) > SAT_LIM) begin
      count_freq = FREQ_MAX;
    end else begin
      count_freq = FREQ_W'(count_x10) << FRAC_BITS;
    end
  end

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  assign rem_shift = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, period_r};
  assign q_bit     = (rem_shift >= {1'b0, period_r});

  // Stability window: 9 * prev <= 10 * f <= 11 * prev.
  assign f_x10    = ({4'b0, meas_r} << 3) + ({4'b0, meas_r} << 1);
  assign prev_x9  = ({4'b0, last_r} << 3) + {4'b0, last_r};
  assign prev_x11 = prev_x9 + ({4'b0, last_r} << 1);
  assign reject   = (f_x10 < prev_x9) || (f_x10 > prev_x11);

  // Status toward the controller.
  assign sts.mode         = mode_r;
  assign sts.freq_ready   = fready_r;
  assign sts.period_ready = pready_r;
  assign sts.use_count    = (count_r >= thr_r);
  assign sts.period_zero  = (period_r == '0);
  assign sts.div_last     = (cnt_r == CNT_W'(DVD_W - 1));
  assign sts.out_free     = !out_valid_r || out_tready;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Captured input item.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r   <= in_tuser[0];
      fready_r <= in_tuser[1];
      pready_r <= in_tuser[2];
      count_r  <= {in_tdata[15:8], 8'b0, in_tdata[7:0]};
      period_r <= {in_tdata[47:32], in_tdata[31:16]};
    end
  end

  // Measured value: count path, zero, or quotient built one bit per step.
  always_comb begin
    meas_nxt = meas_r;
    if (cmd.load_count) begin
      meas_nxt = count_freq;
    end else if (cmd.load_zero || cmd.div_start) begin
      meas_nxt = '0;
    end else if (cmd.div_step) begin
      meas_nxt = {meas_r[FREQ_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    meas_r <= meas_nxt;
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= DIVIDEND;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Qualification state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      acc_freq_r  <= '0;
      acc_valid_r <= 1'b0;
    end else if (cmd.clear_valid) begin
      acc_valid_r <= 1'b0;
    end else if (cmd.qualify) begin
      last_r <= meas_r;
      if (reject) begin
        acc_valid_r <= 1'b0;
      end else begin
        acc_freq_r  <= meas_r;
        acc_valid_r <= 1'b1;
      end
    end
  end

  // Output register; a result waits here until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_freq_r <= acc_valid_r ? acc_freq_r : '0;
      out_flag_r <= acc_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_freq_r};
  assign out_tuser  = out_flag_r;

endmodule

`default_nettype wire

// ----- design/freq_period_meter_qualifier_top.sv -----
// Frequency / period meter with a stability check.
// Input channel (in_*): one measurement event per transfer. tuser carries the
// clear flag and the two ready flags, tdata the gate count bytes and the period.
// Output channel (out_*): exactly one result per input event, the accepted
// frequency (unsigned, FRAC_BITS fraction bits) and its valid flag in tuser.
// A frequency outside 10% of the previous measurement marks the reading invalid.
// Configuration: cfg_wr_en writes the 24-bit count switch threshold.
// Sequence: one item at a time. After the input transfer, a clear or an event
// that changes nothing goes from DEC straight to DONE; the count path and a
// zero period pass QUAL first, and the period path runs the bit-serial divider
// (DIV) before QUAL. out_tvalid rises when DONE loads the output register, and
// the next input transfer is taken once the sequencer is back in IDLE.
// in_tready is high only while no item is in flight.
// A finished result sits in the output register; if the receiver stalls, one
// more item is still accepted and processed, then held until the slot frees.
// Reset clears the threshold to 1000, all history and the valid reading.
`timescale 1ns / 1ps
`default_nettype none

module freq_period_meter_qualifier_top
  import fpmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [THR_W-1:0] cfg_wr_data,  // count_switch_threshold
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // [0] mode, [1] freq_ready, [2] period_ready
  input  wire logic [2:0]       in_tuser,
  // [7:0] count_low_byte, [15:8] count_high_byte, [31:16] period_low,
  // [47:32] period_high
  input  wire logic [47:0]      in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // [35:0] frequency_hz, [39:36] zero
  output logic [39:0]           out_tdata,
  // [0] reading_valid
  output logic                  out_tuser
);

  fpmq_cmd_t cmd;
  fpmq_sts_t sts;

  // Sequencer.
  fpmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Registers, divider, qualification and output stage.
  fpmq_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
